// File: sv/dost_pkg.sv
// ----------------------------------------------------------------------------
// dost_pkg
// Shared types, constants and command structs for the draw-order table.
// ----------------------------------------------------------------------------
`default_nettype none

package dost_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ID_BITS     = 16;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_BITS    = 16;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LAYER  = 2'd1;
    localparam logic [1:0] REQ_Y      = 2'd2;
    localparam logic [1:0] REQ_READ   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // one table entry
    typedef struct packed {
        logic [ID_BITS-1:0]         id;
        logic signed [KEY_BITS-1:0] layer;
        logic signed [KEY_BITS-1:0] y;
    } entry_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_LOAD       = 4'd1,  // capture request, clear pointer and results
        OP_RD_PTR     = 4'd2,  // read memory at ptr
        OP_RD_NEXT    = 4'd3,  // read memory at ptr+1
        OP_RD_PREV    = 4'd4,  // read memory at ptr-1
        OP_RD_SLOT    = 4'd5,  // read memory at slot_index
        OP_PTR_INC    = 4'd6,  // ptr = ptr+1
        OP_TAKE_LAYER = 4'd7,  // held layer = layer of read entry
        OP_SHIFT_UP   = 4'd8,  // write read entry at ptr, ptr up
        OP_SHIFT_DOWN = 4'd9,  // write read entry at ptr, ptr down
        OP_INIT_P     = 4'd10, // ptr = count (or count-1)
        OP_PLACE      = 4'd11, // write held entry at ptr
        OP_GRAB       = 4'd12  // capture read slot result
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       dec_count;  // for INIT_P: use count-1
        logic       inc_count;  // for PLACE: one more entry
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       full;
        logic       cnt_zero;
        logic       ptr_zero;
        logic       ptr_last;   // ptr+1 reaches the entry count
        logic       id_hit;     // read entry holds the request id
        logic       key_less;   // read entry key below held key
        logic       fwd_ok;     // held entry moves past the read entry
        logic       bwd_ok;     // read entry moves past the held entry
    } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/dost_datapath.sv
// ----------------------------------------------------------------------------
// dost_datapath
// Entry memory, walk pointer, held entry and key compare for the table.
// ----------------------------------------------------------------------------
`default_nettype none

module dost_datapath
    import dost_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire dp_cmd_t              cmd,
    output dp_stat_t                  stat,
    input  wire logic [1:0]           in_req,
    input  wire logic [15:0]          in_id,
    input  wire logic signed [15:0]   in_layer,
    input  wire logic signed [15:0]   in_y,
    input  wire logic [7:0]           in_slot,
    output logic [7:0]                res_slot,
    output logic [15:0]               res_entity,
    output logic [8:0]                res_count
);

    entry_t                mem [TABLE_DEPTH];
    entry_t                rd_data_reg;
    entry_t                new_reg;      // entry being placed or moved
    logic [1:0]            req_reg;
    logic [7:0]            slot_reg;
    logic [CNT_BITS-1:0]   ptr_reg, ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [7:0]            res_slot_reg, res_slot_next;
    logic [ID_BITS-1:0]    ent_reg, ent_next;

    logic [ADDR_BITS-1:0]  rd_addr;
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    entry_t                wr_data;
    logic                  less_than;
    logic                  fwd_ok, bwd_ok;

    // strict key compare: stored entry below held key
    assign less_than = ($signed(rd_data_reg.layer) < $signed(new_reg.layer)) ||
                       (rd_data_reg.layer == new_reg.layer &&
                        $signed(rd_data_reg.y) < $signed(new_reg.y));
    assign fwd_ok = rd_data_reg.layer == new_reg.layer &&
                    $signed(new_reg.y) > $signed(rd_data_reg.y);
    assign bwd_ok = rd_data_reg.layer == new_reg.layer &&
                    $signed(new_reg.y) < $signed(rd_data_reg.y);

    // read address selection
    always_comb begin
        unique case (cmd.op)
            OP_RD_SLOT: rd_addr = slot_reg[ADDR_BITS-1:0];
            OP_RD_NEXT: rd_addr = ptr_reg[ADDR_BITS-1:0] + 1'b1;
            OP_RD_PREV: rd_addr = ptr_reg[ADDR_BITS-1:0] - 1'b1;
            default:    rd_addr = ptr_reg[ADDR_BITS-1:0];
        endcase
    end

    assign wr_addr = ptr_reg[ADDR_BITS-1:0];

    // write port, pointer, count and result update
    always_comb begin
        wr_en         = 1'b0;
        wr_data       = new_reg;
        ptr_next      = ptr_reg;
        count_next    = count_reg;
        res_slot_next = res_slot_reg;
        ent_next      = ent_reg;
        unique case (cmd.op)
            OP_LOAD: begin
                ptr_next      = '0;
                res_slot_next = '0;
                ent_next      = '0;
            end
            OP_PTR_INC: ptr_next = ptr_reg + 1'b1;
            OP_SHIFT_UP: begin
                wr_en    = 1'b1;
                wr_data  = rd_data_reg;
                ptr_next = ptr_reg + 1'b1;
            end
            OP_SHIFT_DOWN: begin
                wr_en    = 1'b1;
                wr_data  = rd_data_reg;
                ptr_next = ptr_reg - 1'b1;
            end
            OP_INIT_P: ptr_next = cmd.dec_count ? count_reg - 1'b1 : count_reg;
            OP_PLACE: begin
                wr_en         = 1'b1;
                res_slot_next = ptr_reg[7:0];
                if (cmd.inc_count) count_next = count_reg + 1'b1;
            end
            OP_GRAB: begin
                res_slot_next = slot_reg;
                if ({1'b0, slot_reg} < count_reg) ent_next = rd_data_reg.id;
            end
            default: ;
        endcase
    end

    // entry memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // held request and entry
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            req_reg         <= in_req;
            slot_reg        <= in_slot;
            new_reg.id      <= in_id[ID_BITS-1:0];
            new_reg.layer   <= in_layer;
            new_reg.y       <= in_y;
        end else if (cmd.op == OP_TAKE_LAYER) begin
            new_reg.layer   <= rd_data_reg.layer;
        end
    end

    // control and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg      <= '0;
            count_reg    <= '0;
            res_slot_reg <= '0;
            ent_reg      <= '0;
        end else begin
            ptr_reg      <= ptr_next;
            count_reg    <= count_next;
            res_slot_reg <= res_slot_next;
            ent_reg      <= ent_next;
        end
    end

    // status to the controller
    always_comb begin
        stat.req      = req_reg;
        stat.full     = count_reg == CNT_BITS'(TABLE_DEPTH);
        stat.cnt_zero = count_reg == '0;
        stat.ptr_zero = ptr_reg == '0;
        stat.ptr_last = (ptr_reg + 1'b1) >= count_reg;
        stat.id_hit   = rd_data_reg.id == new_reg.id;
        stat.key_less = less_than;
        stat.fwd_ok   = fwd_ok;
        stat.bwd_ok   = bwd_ok;
    end

    assign res_slot   = res_slot_reg;
    assign res_entity = 16'(ent_reg);
    assign res_count  = 9'(count_reg);

endmodule

`default_nettype wire

// File: sv/dost_ctrl.sv
// ----------------------------------------------------------------------------
// dost_ctrl
// Sequencer for insert, layer change, y change and read walks.
// ----------------------------------------------------------------------------
`default_nettype none

module dost_ctrl
    import dost_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output logic [1:0]     m_status,
    output dp_cmd_t        cmd,
    input  wire dp_stat_t  stat
);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_LOAD  = 15'b000000000000010,
        S_FRD   = 15'b000000000000100,
        S_FCMP  = 15'b000000000001000,
        S_RMRD  = 15'b000000000010000,
        S_RMWR  = 15'b000000000100000,
        S_PRD   = 15'b000000001000000,
        S_PCMP  = 15'b000000010000000,
        S_PLACE = 15'b000000100000000,
        S_YFRD  = 15'b000001000000000,
        S_YFCMP = 15'b000010000000000,
        S_YBRD  = 15'b000100000000000,
        S_YBCMP = 15'b001000000000000,
        S_RDW   = 15'b010000000000000,
        S_DONE  = 15'b100000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic       m_valid_reg, m_valid_next;

    // next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '{op: OP_NONE, dec_count: 1'b0, inc_count: 1'b0};
        unique case (state_reg)
            S_IDLE: if (s_valid && !m_valid_reg) begin
                cmd.op     = OP_LOAD;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                status_next = ST_OK;
                unique case (stat.req)
                    REQ_INSERT: if (stat.full) begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end else begin
                        cmd.op     = OP_INIT_P;
                        state_next = S_PRD;
                    end
                    REQ_READ: begin
                        cmd.op     = OP_RD_SLOT;
                        state_next = S_RDW;
                    end
                    default: if (stat.cnt_zero) begin
                        status_next = ST_NOTFOUND;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_FRD;
                    end
                endcase
            end
            // find: lowest slot holding the id
            S_FRD: begin
                cmd.op     = OP_RD_PTR;
                state_next = S_FCMP;
            end
            S_FCMP: begin
                if (stat.id_hit) begin
                    if (stat.req == REQ_LAYER) begin
                        state_next = S_RMRD;
                    end else begin
                        cmd.op     = OP_TAKE_LAYER;
                        state_next = S_YFRD;
                    end
                end else if (stat.ptr_last) begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_DONE;
                end else begin
                    cmd.op     = OP_PTR_INC;
                    state_next = S_FRD;
                end
            end
            // remove: pull entries down from ptr+1
            S_RMRD: begin
                if (stat.ptr_last) begin
                    cmd.op        = OP_INIT_P;
                    cmd.dec_count = 1'b1;
                    state_next    = S_PRD;
                end else begin
                    cmd.op     = OP_RD_NEXT;
                    state_next = S_RMWR;
                end
            end
            S_RMWR: begin
                cmd.op     = OP_SHIFT_UP;
                state_next = S_RMRD;
            end
            // insert: read ptr-1, shift up or stop
            S_PRD: begin
                if (stat.ptr_zero) begin
                    state_next = S_PLACE;
                end else begin
                    cmd.op     = OP_RD_PREV;
                    state_next = S_PCMP;
                end
            end
            S_PCMP: begin
                if (stat.key_less) begin
                    state_next = S_PLACE;
                end else begin
                    cmd.op     = OP_SHIFT_DOWN;
                    state_next = S_PRD;
                end
            end
            S_PLACE: begin
                cmd.op        = OP_PLACE;
                cmd.inc_count = stat.req == REQ_INSERT;
                state_next    = S_DONE;
            end
            // y change: bubble forward past same-layer neighbors
            S_YFRD: begin
                if (stat.ptr_last) begin
                    state_next = S_YBRD;
                end else begin
                    cmd.op     = OP_RD_NEXT;
                    state_next = S_YFCMP;
                end
            end
            S_YFCMP: begin
                if (stat.fwd_ok) begin
                    cmd.op     = OP_SHIFT_UP;
                    state_next = S_YFRD;
                end else begin
                    state_next = S_YBRD;
                end
            end
            // y change: then bubble backward
            S_YBRD: begin
                if (stat.ptr_zero) begin
                    state_next = S_PLACE;
                end else begin
                    cmd.op     = OP_RD_PREV;
                    state_next = S_YBCMP;
                end
            end
            S_YBCMP: begin
                if (stat.bwd_ok) begin
                    cmd.op     = OP_SHIFT_DOWN;
                    state_next = S_YBRD;
                end else begin
                    state_next = S_PLACE;
                end
            end
            S_RDW: begin
                cmd.op     = OP_GRAB;
                state_next = S_DONE;
            end
            S_DONE: begin
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            status_reg  <= ST_OK;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            status_reg  <= status_next;
        end
    end

    assign s_ready  = state_reg == S_IDLE && !m_valid_reg;
    assign m_valid  = m_valid_reg;
    assign m_status = status_reg;

    // checks
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("accept while result pending");
    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE |=> m_valid) else $error("result not raised");
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_FULL || m_status == ST_NOTFOUND))
        else $error("bad status");

endmodule

`default_nettype wire

// File: sv/draw_order_sorted_table_top.sv
// ----------------------------------------------------------------------------
// draw_order_sorted_table_top
// Sorted draw-order table of sprite ids keyed by (layer, y).
// ----------------------------------------------------------------------------
// One request is handled at a time; the next transfer is taken once the
// result has been taken. Every walk step reads an entry and then compares
// and moves it, because the entry memory has a registered read. An insert
// walks down from the end of the table; a layer change finds the entry,
// then removes and reinserts it; a y change finds it and bubbles it forward
// and then backward. Entries are uninitialized after reset; only the fill
// count, walk pointer and result registers are cleared.
`default_nettype none

module draw_order_sorted_table_top
    import dost_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_req_type,
    input  wire logic [15:0]        s_entity_id,
    input  wire logic signed [15:0] s_layer_key,
    input  wire logic signed [15:0] s_y_key,
    input  wire logic [7:0]         s_slot_index,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic [7:0]              m_final_slot,
    output logic [15:0]             m_slot_entity,
    output logic [8:0]              m_entry_count
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dost_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .m_status, .cmd, .stat
    );

    dost_datapath u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .in_req(s_req_type), .in_id(s_entity_id), .in_layer(s_layer_key),
        .in_y(s_y_key), .in_slot(s_slot_index),
        .res_slot(m_final_slot), .res_entity(m_slot_entity),
        .res_count(m_entry_count)
    );

endmodule

`default_nettype wire
